// ===== rtl/sfs_pkg.sv =====
// ----------------------------------------------------------------------------
// sfs_pkg
// Shared widths, defaults, register codes and pipeline item type for the
// saturating frame stacker.
// ----------------------------------------------------------------------------
package sfs_pkg;

	localparam int PIX_W     = 16;
	localparam int IDX_W     = 19;
	localparam int COL_W     = 10;
	localparam int ROW_W     = 9;
	localparam int FRM_W     = 10;
	localparam int WID_W     = 11;
	localparam int HGT_W     = 10;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 11;

	localparam int MAX_PIXELS_DEF = 524288;
	localparam int PIXEL_BITS_DEF = 16;

	localparam logic [WID_W-1:0] WIDTH_RST  = WID_W'(640);
	localparam logic [HGT_W-1:0] HEIGHT_RST = HGT_W'(480);
	localparam logic [FRM_W-1:0] FRAMES_RST = FRM_W'(1);

	localparam logic [WID_W-1:0] WIDTH_MAX  = WID_W'(1024);
	localparam logic [HGT_W-1:0] HEIGHT_MAX = HGT_W'(512);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_WIDTH  = 2'd0,
		CFG_HEIGHT = 2'd1,
		CFG_FRAMES = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic [PIX_W-1:0] pix;
		logic [IDX_W-1:0] idx;
		logic             first;
		logic             emit;
		logic             last_px;
	} item_t;

endpackage

// ===== rtl/sfs_if.sv =====
// ----------------------------------------------------------------------------
// sfs_if
// Valid/ready channels: raw pixel input, stacked result output, register
// write port.
// ----------------------------------------------------------------------------
interface sfs_in_if;
	logic        valid;
	logic        ready;
	logic [15:0] raw_pixel;

	modport source (output valid, output raw_pixel, input ready);
	modport sink (input valid, input raw_pixel, output ready);
endinterface

interface sfs_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] stacked_value;
	logic [18:0] pixel_index;
	logic        clipped;
	logic        last_pixel;

	modport source (output valid, output stacked_value, output pixel_index,
		output clipped, output last_pixel, input ready);
	modport sink (input valid, input stacked_value, input pixel_index,
		input clipped, input last_pixel, output ready);
endinterface

interface sfs_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [10:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/saturating_frame_stacker_core.sv =====
// ----------------------------------------------------------------------------
// saturating_frame_stacker_core
// Sums a configured number of frames per pixel into a store, saturating on
// overflow, and emits the stacked image during the last frame.
//
// Channel   Dir  Request payload
// pix_in    in   raw_pixel (16b, big-endian)
// res_out   out  stacked_value, pixel_index, clipped, last_pixel
// cfg       in   index (0 width, 1 height, 2 frames), data (11b)
//
// One pixel per cycle unless a held result stalls input; result is registered.
// Throughput is set by the single read-modify-write port pair of the store.
// Reset clears counters and loads 640 x 480, 1 frame; the store is not cleared.
// A held result stalls input only when the next result reaches the write stage.
// ----------------------------------------------------------------------------
module saturating_frame_stacker_core import sfs_pkg::*; #(
	parameter int MAX_PIXELS = MAX_PIXELS_DEF,
	parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	sfs_in_if.sink    pix_in,
	sfs_out_if.source res_out,
	sfs_cfg_if.sink   cfg
);

	localparam int AW = $clog2(MAX_PIXELS);

	logic [WID_W-1:0]   width_q;
	logic [HGT_W-1:0]   height_q;
	logic [FRM_W-1:0]   frames_q;
	logic [COL_W-1:0]   col_q;
	logic [ROW_W-1:0]   row_q;
	logic [FRM_W-1:0]   frm_q;
	logic [WID_W-1:0]   w;
	logic [HGT_W-1:0]   h;
	logic [FRM_W-1:0]   f;
	logic               end_row;
	logic               end_frame;
	logic               last_frame;
	logic               adv;
	logic               in_acc;
	logic [IDX_W:0]     idx_full;
	item_t              item_next;
	logic               vld_s1;
	item_t              item_s1;
	logic               vld_s3;
	item_t              item_s3;
	logic [AW-1:0]      rd_addr;

	assign cfg.ready    = 1'b1;
	assign pix_in.ready = adv;
	assign in_acc       = pix_in.valid & adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RST;
			height_q <= HEIGHT_RST;
			frames_q <= FRAMES_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_WIDTH:  width_q  <= cfg.data;
				CFG_HEIGHT: height_q <= cfg.data[HGT_W-1:0];
				CFG_FRAMES: frames_q <= cfg.data[FRM_W-1:0];
				default:    ;
			endcase
		end
	end

	always_comb begin
		w = (width_q == '0) ? WID_W'(1) : (width_q > WIDTH_MAX) ? WIDTH_MAX : width_q;
		h = (height_q == '0) ? HGT_W'(1) : (height_q > HEIGHT_MAX) ? HEIGHT_MAX : height_q;
		f = (frames_q == '0) ? FRM_W'(1) : frames_q;
		end_row    = ({1'b0, col_q} + WID_W'(1)) >= w;
		end_frame  = end_row && (({1'b0, row_q} + HGT_W'(1)) >= h);
		last_frame = ({1'b0, frm_q} + (FRM_W + 1)'(1)) >= {1'b0, f};
		idx_full   = (IDX_W + 1)'(row_q) * (IDX_W + 1)'(w) + (IDX_W + 1)'(col_q);
		item_next.pix     = {pix_in.raw_pixel[7:0], pix_in.raw_pixel[15:8]};
		item_next.idx     = idx_full[IDX_W-1:0];
		item_next.first   = (frm_q == '0);
		item_next.emit    = last_frame;
		item_next.last_px = end_frame;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			frm_q  <= '0;
			vld_s1 <= 1'b0;
		end else begin
			if (adv) begin
				vld_s1 <= in_acc;
			end
			if (in_acc) begin
				if (end_row) begin
					col_q <= '0;
					if (end_frame) begin
						row_q <= '0;
						frm_q <= last_frame ? '0 : frm_q + FRM_W'(1);
					end else begin
						row_q <= row_q + ROW_W'(1);
					end
				end else begin
					col_q <= col_q + COL_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			item_s1 <= item_next;
		end
	end

	sfs_addr #(
		.MAX_PIXELS (MAX_PIXELS)
	) u_addr (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.vld_s1  (vld_s1),
		.item_s1 (item_s1),
		.vld_s3  (vld_s3),
		.item_s3 (item_s3),
		.rd_addr (rd_addr)
	);

	sfs_accum #(
		.MAX_PIXELS (MAX_PIXELS),
		.PIXEL_BITS (PIXEL_BITS)
	) u_accum (
		.clk     (clk),
		.arst_n  (arst_n),
		.vld_s3  (vld_s3),
		.item_s3 (item_s3),
		.rd_addr (rd_addr),
		.adv     (adv),
		.res_out (res_out)
	);

endmodule

// ===== rtl/sfs_ram.sv =====
// ----------------------------------------------------------------------------
// sfs_ram
// Generic single-write, single-read RAM with registered read (read-first).
// ----------------------------------------------------------------------------
module sfs_ram #(
	parameter int WIDTH = 17,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/sfs_addr.sv =====
// ----------------------------------------------------------------------------
// sfs_addr
// Store address unit: reduces the row-major index modulo the store depth by
// reciprocal multiply, back-multiply and one correction step.
// ----------------------------------------------------------------------------
module sfs_addr import sfs_pkg::*; #(
	parameter int MAX_PIXELS = MAX_PIXELS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          adv,
	input  logic                          vld_s1,
	input  item_t                         item_s1,
	output logic                          vld_s3,
	output item_t                         item_s3,
	output logic [$clog2(MAX_PIXELS)-1:0] rd_addr
);

	localparam int AW    = $clog2(MAX_PIXELS);
	localparam int MW    = $clog2(MAX_PIXELS + 1);
	localparam int RECIP = (2 ** IDX_W) / MAX_PIXELS;
	localparam int RW    = (RECIP < 2) ? 1 : $clog2(RECIP + 1);
	localparam int CW    = (MW > IDX_W) ? MW : IDX_W;

	localparam logic [RW-1:0] RECIP_C = RW'(RECIP);
	localparam logic [MW-1:0] DEPTH_C = MW'(MAX_PIXELS);
	localparam logic [CW-1:0] DEPTH_W = CW'(MAX_PIXELS);

	logic                 vld_s2;
	item_t                item_s2;
	logic [RW-1:0]        q_s2;
	logic [IDX_W+RW-1:0]  prod;
	logic [RW+MW-1:0]     qm;
	logic [IDX_W-1:0]     rem_s3;
	logic [CW-1:0]        rem_ext;
	logic [CW-1:0]        rem_fix;

	// quotient estimate, low by at most one
	assign prod = (IDX_W + RW)'(item_s1.idx) * (IDX_W + RW)'(RECIP_C);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	assign qm = (RW + MW)'(q_s2) * (RW + MW)'(DEPTH_C);

	always_ff @(posedge clk) begin
		if (adv) begin
			item_s2 <= item_s1;
			q_s2    <= prod[IDX_W +: RW];
			item_s3 <= item_s2;
			rem_s3  <= item_s2.idx - qm[IDX_W-1:0];
		end
	end

	assign rem_ext = CW'(rem_s3);
	assign rem_fix = (rem_ext >= DEPTH_W) ? rem_ext - DEPTH_W : rem_ext;
	assign rd_addr = rem_fix[AW-1:0];

endmodule

// ===== rtl/sfs_accum.sv =====
// ----------------------------------------------------------------------------
// sfs_accum
// Read-modify-write stage on the pixel/clip store with write-to-read
// forwarding, saturating add, and the result register.
// ----------------------------------------------------------------------------
module sfs_accum import sfs_pkg::*; #(
	parameter int MAX_PIXELS = MAX_PIXELS_DEF,
	parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          vld_s3,
	input  item_t                         item_s3,
	input  logic [$clog2(MAX_PIXELS)-1:0] rd_addr,
	output logic                          adv,
	sfs_out_if.source                     res_out
);

	localparam int AW = $clog2(MAX_PIXELS);
	localparam int DW = PIXEL_BITS + 1;

	logic                  vld_s4;
	item_t                 item_s4;
	logic [AW-1:0]         addr_s4;
	logic [DW-1:0]         rdata;
	logic [DW-1:0]         wdata;
	logic                  byp_vld_q;
	logic [AW-1:0]         byp_addr_q;
	logic [DW-1:0]         byp_data_q;
	logic [DW-1:0]         old;
	logic [PIXEL_BITS-1:0] pix;
	logic [PIXEL_BITS:0]   raw_sum;
	logic [PIXEL_BITS-1:0] sum;
	logic                  clip;
	logic                  vld_s5;
	logic                  out_acc;

	assign out_acc = res_out.valid & res_out.ready;
	assign adv     = !vld_s5 || res_out.ready || !(vld_s4 && item_s4.emit);

	sfs_ram #(
		.WIDTH (DW),
		.DEPTH (MAX_PIXELS)
	) u_store (
		.clk   (clk),
		.we    (adv & vld_s4),
		.waddr (addr_s4),
		.wdata (wdata),
		.re    (adv),
		.raddr (rd_addr),
		.rdata (rdata)
	);

	// the RAM returns old data when the previous item writes the same entry
	assign old = (byp_vld_q && byp_addr_q == addr_s4) ? byp_data_q : rdata;
	assign pix = item_s4.pix[PIXEL_BITS-1:0];

	always_comb begin
		raw_sum = {1'b0, old[PIXEL_BITS-1:0]} + {1'b0, pix};
		if (item_s4.first) begin
			sum  = pix;
			clip = 1'b0;
		end else if (raw_sum[PIXEL_BITS]) begin
			sum  = '1;
			clip = 1'b1;
		end else begin
			sum  = raw_sum[PIXEL_BITS-1:0];
			clip = old[PIXEL_BITS];
		end
		wdata = {clip, sum};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4    <= 1'b0;
			byp_vld_q <= 1'b0;
			vld_s5    <= 1'b0;
		end else begin
			if (adv) begin
				vld_s4    <= vld_s3;
				byp_vld_q <= vld_s4;
			end
			if (out_acc) begin
				vld_s5 <= 1'b0;
			end
			if (adv && vld_s4 && item_s4.emit) begin
				vld_s5 <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			item_s4    <= item_s3;
			addr_s4    <= rd_addr;
			byp_addr_q <= addr_s4;
			byp_data_q <= wdata;
		end
		if (adv && vld_s4 && item_s4.emit) begin
			res_out.stacked_value <= PIX_W'(sum);
			res_out.pixel_index   <= item_s4.idx;
			res_out.clipped       <= clip;
			res_out.last_pixel    <= item_s4.last_px;
		end
	end

	assign res_out.valid = vld_s5;

endmodule

// ===== rtl/sfs_checker.sv =====
// ----------------------------------------------------------------------------
// sfs_checker
// Port-level checks on the stacker core, attached by bind.
// ----------------------------------------------------------------------------
module sfs_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [15:0] out_value,
	input logic [18:0] out_index,
	input logic        out_clipped,
	input logic        out_last
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result request dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_value) && $stable(out_index)
			&& $stable(out_clipped) && $stable(out_last))
		else $error("result payload changed while stalled");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty result register");

	a_reset_empty: assert property (@(posedge clk)
		!arst_n |=> !out_valid)
		else $error("result valid right after reset");

endmodule

bind saturating_frame_stacker_core sfs_checker u_sfs_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_ready    (pix_in.ready),
	.out_valid   (res_out.valid),
	.out_ready   (res_out.ready),
	.out_value   (res_out.stacked_value),
	.out_index   (res_out.pixel_index),
	.out_clipped (res_out.clipped),
	.out_last    (res_out.last_pixel)
);

// ===== tb/tb_saturating_frame_stacker_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_saturating_frame_stacker_core
// Self-checking bench for the frame stacker. A directed table covers reset
// geometry, byte swap, saturation, sticky clip, zero addend, register clamping
// and register changes mid-stack. Random stacks of small images follow, plus
// one run down to the last row of the largest frame. Every result is checked
// in order against a behavioral model of the stacking arithmetic, or against
// the table value for checked rows, with random stalls on both channels.
// ----------------------------------------------------------------------------
module tb_saturating_frame_stacker_core;
	import sfs_pkg::*;

	localparam int unsigned PIXEL_MAX    = 32'hFFFF;
	localparam int unsigned STORE_DEPTH  = MAX_PIXELS_DEF;
	localparam int          DRAIN        = 16;
	localparam int          RANDOM_ITEMS = 1450;
	localparam int          LIMIT        = 400000;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

	typedef struct packed {
		logic [PIX_W-1:0] value;
		logic [IDX_W-1:0] index;
		logic             clipped;
		logic             last;
	} stack_result_t;

	typedef struct {
		bit                   is_reg;
		logic [CFG_IDX_W-1:0] reg_idx;
		logic [CFG_DAT_W-1:0] reg_data;
		logic [PIX_W-1:0]     raw;
		bit                   typed;
		stack_result_t        want;
	} stim_row_t;

	logic clk;
	logic arst_n;

	sfs_in_if  pix_if ();
	sfs_out_if res_if ();
	sfs_cfg_if cfg_if ();

	saturating_frame_stacker_core DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.pix_in  (pix_if),
		.res_out (res_if),
		.cfg     (cfg_if)
	);

	// model state
	logic [WID_W-1:0] cfg_width;
	logic [HGT_W-1:0] cfg_height;
	logic [FRM_W-1:0] cfg_frames;
	bit [PIX_W-1:0]   acc_store [STORE_DEPTH];
	bit               clip_flags [STORE_DEPTH];
	logic [COL_W-1:0] col_cnt;
	logic [ROW_W-1:0] row_cnt;
	logic [FRM_W-1:0] frm_cnt;

	stack_result_t pending_sums [$];
	stim_row_t     directed_rows [$];
	int            errors;
	int            sent_count;
	int            cycle_cnt;
	bit            calm;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		res_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			res_if.ready <= calm || ($urandom_range(99) >= 14);
		end
	end

	always @(posedge clk) begin : result_check
		stack_result_t want;
		if (arst_n && res_if.valid && res_if.ready) begin
			if (pending_sums.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result: value %h index %0d clip %b last %b",
						res_if.stacked_value, res_if.pixel_index, res_if.clipped,
						res_if.last_pixel);
			end else begin
				want = pending_sums.pop_front();
				if (res_if.stacked_value !== want.value || res_if.pixel_index !== want.index ||
					res_if.clipped !== want.clipped || res_if.last_pixel !== want.last) begin
					errors++;
					if (errors <= 10)
						$display("mismatch: exp %h/%0d/%b/%b got %h/%0d/%b/%b",
							want.value, want.index, want.clipped, want.last,
							res_if.stacked_value, res_if.pixel_index, res_if.clipped,
							res_if.last_pixel);
				end
			end
		end
	end

	function automatic int unsigned clamp_dim(int unsigned v, int unsigned lo, int unsigned hi);
		if (v < lo)
			return lo;
		if (v > hi)
			return hi;
		return v;
	endfunction

	task automatic stack_pixel(input logic [PIX_W-1:0] raw, output bit emit,
		output stack_result_t res);
		int unsigned w, h, f, pix, idx, addr, sum;
		bit clip, end_row, end_frame, last_frame;
		w = clamp_dim(cfg_width, 1, 1024);
		h = clamp_dim(cfg_height, 1, 512);
		f = clamp_dim(cfg_frames, 1, 1023);
		pix = 32'({raw[7:0], raw[15:8]});
		idx = row_cnt * w + col_cnt;
		addr = idx % STORE_DEPTH;
		end_row = (col_cnt + 1 >= w);
		end_frame = end_row && (row_cnt + 1 >= h);
		last_frame = (frm_cnt + 1 >= f);
		if (frm_cnt == 0) begin
			sum = pix;
			clip = 1'b0;
		end else begin
			sum = acc_store[addr] + pix;
			clip = clip_flags[addr];
			if (sum > PIXEL_MAX) begin
				sum = PIXEL_MAX;
				clip = 1'b1;
			end
		end
		acc_store[addr] = 16'(sum);
		clip_flags[addr] = clip;
		emit = last_frame;
		res.value = 16'(sum);
		res.index = 19'(idx);
		res.clipped = clip;
		res.last = end_frame;
		if (end_row) begin
			col_cnt = '0;
			if (end_frame) begin
				row_cnt = '0;
				frm_cnt = last_frame ? '0 : FRM_W'(frm_cnt + 1);
			end else begin
				row_cnt = ROW_W'(row_cnt + 1);
			end
		end else begin
			col_cnt = COL_W'(col_cnt + 1);
		end
	endtask

	task automatic send_pixel(input logic [PIX_W-1:0] raw, input bit typed,
		input stack_result_t want);
		bit emit;
		stack_result_t res;
		@(negedge clk);
		while (!calm && $urandom_range(99) < 14) begin
			pix_if.valid <= 1'b0;
			@(negedge clk);
		end
		pix_if.valid <= 1'b1;
		pix_if.raw_pixel <= raw;
		@(posedge clk);
		while (!pix_if.ready)
			@(posedge clk);
		sent_count++;
		stack_pixel(raw, emit, res);
		if (emit)
			pending_sums.push_back(typed ? want : res);
	endtask

	task automatic quiesce();
		@(negedge clk);
		pix_if.valid <= 1'b0;
		while (pending_sums.size() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
		quiesce();
		@(negedge clk);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data <= data;
		@(posedge clk);
		while (!cfg_if.ready)
			@(posedge clk);
		case (idx)
			CFG_WIDTH:  cfg_width = data;
			CFG_HEIGHT: cfg_height = HGT_W'(data);
			CFG_FRAMES: cfg_frames = FRM_W'(data);
			default: ;
		endcase
		@(negedge clk);
		cfg_if.valid <= 1'b0;
	endtask

	function automatic logic [PIX_W-1:0] rand_raw();
		case ($urandom_range(9))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2: return {8'($urandom_range(255)), 8'h00};
			3, 4: return {8'($urandom_range(255)), 8'($urandom_range(128, 255))};
			default: return 16'($urandom_range(65535));
		endcase
	endfunction

	task automatic feed_pixels(input int n);
		repeat (n) send_pixel(rand_raw(), 1'b0, '0);
	endtask

	task automatic feed_to_boundary();
		while (col_cnt != 0 || row_cnt != 0 || frm_cnt != 0)
			send_pixel(rand_raw(), 1'b0, '0);
	endtask

	function automatic logic [CFG_DAT_W-1:0] pick_dim(int unsigned top);
		if ($urandom_range(7) == 0)
			return '0;
		return CFG_DAT_W'($urandom_range(1, top));
	endfunction

	function automatic logic [CFG_DAT_W-1:0] pick_frames();
		int unsigned r;
		r = $urandom_range(19);
		if (r < 2)
			return '0;
		if (r < 6)
			return CFG_DAT_W'(1);
		if (r < 18)
			return CFG_DAT_W'($urandom_range(2, 6));
		return CFG_DAT_W'($urandom_range(7, 16));
	endfunction

	function automatic stim_row_t reg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
		stim_row_t r;
		r.is_reg = 1'b1;
		r.reg_idx = idx;
		r.reg_data = data;
		r.raw = '0;
		r.typed = 1'b0;
		r.want = '0;
		return r;
	endfunction

	function automatic stim_row_t pix_row(logic [PIX_W-1:0] raw);
		stim_row_t r;
		r.is_reg = 1'b0;
		r.reg_idx = '0;
		r.reg_data = '0;
		r.raw = raw;
		r.typed = 1'b0;
		r.want = '0;
		return r;
	endfunction

	function automatic stim_row_t pix_chk(logic [PIX_W-1:0] raw, logic [PIX_W-1:0] value,
		logic [IDX_W-1:0] index, logic clipped, logic last);
		stim_row_t r;
		r = pix_row(raw);
		r.typed = 1'b1;
		r.want = '{value: value, index: index, clipped: clipped, last: last};
		return r;
	endfunction

	initial begin
		int random_base;
		int phase_no;
		int unsigned w, h, f, per_stack;
		stim_row_t row;

		arst_n = 1'b0;
		pix_if.valid = 1'b0;
		pix_if.raw_pixel = '0;
		cfg_if.valid = 1'b0;
		cfg_if.index = '0;
		cfg_if.data = '0;
		errors = 0;
		sent_count = 0;
		cycle_cnt = 0;
		calm = 1'b0;
		cfg_width = WIDTH_RST;
		cfg_height = HEIGHT_RST;
		cfg_frames = FRAMES_RST;
		col_cnt = '0;
		row_cnt = '0;
		frm_cnt = '0;

		// reset geometry, byte swap
		directed_rows.push_back(pix_chk(16'h1234, 16'h3412, 19'd0, 1'b0, 1'b0));
		directed_rows.push_back(pix_chk(16'hFFFF, 16'hFFFF, 19'd1, 1'b0, 1'b0));
		directed_rows.push_back(pix_chk(16'h0000, 16'h0000, 19'd2, 1'b0, 1'b0));
		// shrink mid-frame: row and frame end at next pixel
		directed_rows.push_back(reg_row(CFG_WIDTH, 11'd1));
		directed_rows.push_back(reg_row(CFG_HEIGHT, 11'd1));
		directed_rows.push_back(pix_row(16'h00FF));
		// zero addend, real wrap, exact max
		directed_rows.push_back(reg_row(CFG_FRAMES, 11'd2));
		directed_rows.push_back(pix_row(16'hFFFF));
		directed_rows.push_back(pix_chk(16'h0000, 16'hFFFF, 19'd0, 1'b0, 1'b1));
		directed_rows.push_back(pix_row(16'h0080));
		directed_rows.push_back(pix_chk(16'h0080, 16'hFFFF, 19'd0, 1'b1, 1'b1));
		directed_rows.push_back(pix_row(16'hFF7F));
		directed_rows.push_back(pix_chk(16'h0080, 16'hFFFF, 19'd0, 1'b0, 1'b1));
		// sticky clip, then cleared by the next first frame
		directed_rows.push_back(reg_row(CFG_FRAMES, 11'd3));
		directed_rows.push_back(pix_row(16'h0080));
		directed_rows.push_back(pix_row(16'h0080));
		directed_rows.push_back(pix_chk(16'h0000, 16'hFFFF, 19'd0, 1'b1, 1'b1));
		directed_rows.push_back(pix_row(16'h0100));
		directed_rows.push_back(pix_row(16'h0100));
		directed_rows.push_back(pix_chk(16'h0100, 16'h0003, 19'd0, 1'b0, 1'b1));
		// unused register index, zero registers act as one
		directed_rows.push_back(reg_row(CFG_SPARE, 11'h7FF));
		directed_rows.push_back(reg_row(CFG_FRAMES, 11'd0));
		directed_rows.push_back(reg_row(CFG_WIDTH, 11'd0));
		directed_rows.push_back(reg_row(CFG_HEIGHT, 11'd0));
		directed_rows.push_back(pix_chk(16'hABCD, 16'hCDAB, 19'd0, 1'b0, 1'b1));
		// upper data bits masked; frame count cut short mid-stack
		directed_rows.push_back(reg_row(CFG_WIDTH, 11'd2));
		directed_rows.push_back(reg_row(CFG_HEIGHT, 11'h402));
		directed_rows.push_back(reg_row(CFG_FRAMES, 11'h7FF));
		directed_rows.push_back(pix_row(16'h8001));
		directed_rows.push_back(pix_row(16'h7FFE));
		directed_rows.push_back(pix_row(16'h0000));
		directed_rows.push_back(pix_row(16'hFFFF));
		directed_rows.push_back(reg_row(CFG_FRAMES, 11'd1));
		directed_rows.push_back(pix_row(16'h0180));
		directed_rows.push_back(pix_row(16'h0280));
		directed_rows.push_back(pix_row(16'h1234));
		directed_rows.push_back(pix_row(16'h0001));

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (directed_rows[i]) begin
			row = directed_rows[i];
			if (row.is_reg)
				write_reg(row.reg_idx, row.reg_data);
			else
				send_pixel(row.raw, row.typed, row.want);
		end

		random_base = sent_count;
		phase_no = 0;
		while (sent_count - random_base < RANDOM_ITEMS) begin
			calm = (sent_count - random_base >= 500) &&
				(sent_count - random_base < 800);
			if (phase_no == 8) begin
				// walk down one column, then widen on the last row of the largest frame
				write_reg(CFG_FRAMES, 11'd1);
				write_reg(CFG_WIDTH, 11'd1);
				write_reg(CFG_HEIGHT, 11'h7FF);
				feed_pixels(511);
				write_reg(CFG_WIDTH, 11'h7FF);
				feed_pixels(4);
				write_reg(CFG_WIDTH, 11'd1);
				feed_to_boundary();
			end else begin
				write_reg(CFG_WIDTH, pick_dim(8));
				write_reg(CFG_HEIGHT, pick_dim(4));
				write_reg(CFG_FRAMES, pick_frames());
				w = clamp_dim(cfg_width, 1, 1024);
				h = clamp_dim(cfg_height, 1, 512);
				f = clamp_dim(cfg_frames, 1, 1023);
				per_stack = w * h * f;
				feed_pixels(per_stack * $urandom_range(1, 2));
				if ($urandom_range(2) == 0 && per_stack > 1) begin
					feed_pixels($urandom_range(1, per_stack - 1));
					if (f == 1) begin
						write_reg(CFG_WIDTH, pick_dim(8));
						write_reg(CFG_HEIGHT, pick_dim(4));
					end else begin
						write_reg(CFG_FRAMES, pick_frames());
					end
					feed_to_boundary();
				end
			end
			phase_no++;
		end
		calm = 1'b0;

		quiesce();
		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/sfs_pkg.sv
rtl/sfs_if.sv
rtl/sfs_ram.sv
rtl/sfs_addr.sv
rtl/sfs_accum.sv
rtl/saturating_frame_stacker_core.sv
rtl/sfs_checker.sv
tb/tb_saturating_frame_stacker_core.sv
